// ===== rtl/fexc_pkg.sv =====
// shared constants, types and helpers for the excitation address and sign block
package fexc_pkg;

   localparam int DEF_MAX_ORBITALS  = 32;
   localparam int DEF_MAX_OPERATORS = 4;
   localparam int DATA_W            = 32;
   localparam int ENTRY_W           = 5;
   localparam int ORBITAL_COUNT_W   = 6;
   localparam int COUNT_W           = 3;
   localparam int CSR_INDEX_W       = 3;
   localparam int POS_W             = 7;

   localparam logic [ORBITAL_COUNT_W-1:0] RESET_ORBITAL_COUNT = 6'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ORBITAL_COUNT  = 3'd0,
      REG_HOLE_COUNT     = 3'd1,
      REG_PARTICLE_COUNT = 3'd2,
      REG_HOLE_LIST      = 3'd3,
      REG_PARTICLE_LIST  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              null_operator;
      logic              inversion_parity;
      logic [DATA_W-1:0] range_mask;
   } fexc_decode_type;

   typedef struct packed {
      logic [DATA_W-1:0] hole_address;
      logic [DATA_W-1:0] particle_address;
      logic              sign_negative;
      logic              null_operator;
      logic              out_of_range;
   } fexc_result_type;

   function automatic int csr_width(int max_operators);
      int list_w;
      list_w = ENTRY_W * max_operators;
      return (list_w > ORBITAL_COUNT_W) ? list_w : ORBITAL_COUNT_W;
   endfunction

   function automatic int shift_width(int max_operators);
      return $clog2(2 * max_operators + 1);
   endfunction

endpackage

// ===== rtl/fexc_channels.sv =====
// request and response channel interfaces
interface fexc_req_if;
   import fexc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] spectator_index;

   modport source(output valid, output spectator_index, input ready);
   modport sink(input valid, input spectator_index, output ready);
endinterface

interface fexc_rsp_if;
   import fexc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] hole_address;
   logic [DATA_W-1:0] particle_address;
   logic              sign_negative;
   logic              null_operator;
   logic              out_of_range;

   modport source(output valid, output hole_address, output particle_address,
                  output sign_negative, output null_operator, output out_of_range,
                  input ready);
   modport sink(input valid, input hole_address, input particle_address,
                input sign_negative, input null_operator, input out_of_range,
                output ready);
endinterface

// ===== rtl/fermion_excitation_index_and_sign.sv =====
// Expands one compacted spectator index per clock into the hole and particle determinant
// addresses and the fermionic phase bit. Throughput is one item per cycle; an accepted item
// sits in the input register, and the zero-insertion, range and parity logic loads its
// result into the result register, which offers it, when that is empty or being taken;
// a stalled result stalls the input side. Register writes are decoded into per-orbital
// masks and shift counts by a registered decode stage, so items accepted from the cycle
// after the last write use the new setting.
// A null operator or an out-of-range spectator index returns zero addresses and sign with
// the matching flag set.
module fermion_excitation_index_and_sign #(
   parameter int MAX_ORBITALS  = fexc_pkg::DEF_MAX_ORBITALS,
   parameter int MAX_OPERATORS = fexc_pkg::DEF_MAX_OPERATORS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   fexc_req_if.sink                                      req_if,
   fexc_rsp_if.source                                    rsp_if,
   input  logic                                          csr_write_enable,
   input  logic [fexc_pkg::CSR_INDEX_W-1:0]              csr_index,
   input  logic [fexc_pkg::csr_width(MAX_OPERATORS)-1:0] csr_write_data
);
   import fexc_pkg::*;

   localparam int SHIFT_W = shift_width(MAX_OPERATORS);

   fexc_decode_type                      decode;
   logic [MAX_ORBITALS-1:0]              hole_mask;
   logic [MAX_ORBITALS-1:0]              particle_mask;
   logic [MAX_ORBITALS-1:0]              sign_mask;
   logic [MAX_ORBITALS-1:0][SHIFT_W-1:0] shift_count;

   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_spec_ff;
   logic              s2_valid_ff, s2_valid_in;
   fexc_result_type   s2_result_ff;
   fexc_result_type   result;
   logic              req_accept;
   logic              s2_load;

   fexc_cfg #(
      .MAX_ORBITALS (MAX_ORBITALS),
      .MAX_OPERATORS(MAX_OPERATORS)
   ) u_cfg (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .decode          (decode),
      .hole_mask       (hole_mask),
      .particle_mask   (particle_mask),
      .sign_mask       (sign_mask),
      .shift_count     (shift_count)
   );

   fexc_expand #(
      .MAX_ORBITALS (MAX_ORBITALS),
      .MAX_OPERATORS(MAX_OPERATORS)
   ) u_expand (
      .spectator_index(s1_spec_ff),
      .decode         (decode),
      .hole_mask      (hole_mask),
      .particle_mask  (particle_mask),
      .sign_mask      (sign_mask),
      .shift_count    (shift_count),
      .result         (result)
   );

   // the result register frees when empty or taken this cycle
   assign s2_load      = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || !s2_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept)   s1_valid_in = 1'b1;
      else if (s2_load) s1_valid_in = 1'b0;

      s2_valid_in = s2_valid_ff;
      if (s2_load)            s2_valid_in = 1'b1;
      else if (rsp_if.ready)  s2_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (req_accept) s1_spec_ff   <= req_if.spectator_index;
      if (s2_load)    s2_result_ff <= result;
   end

   assign rsp_if.valid            = s2_valid_ff;
   assign rsp_if.hole_address     = s2_result_ff.hole_address;
   assign rsp_if.particle_address = s2_result_ff.particle_address;
   assign rsp_if.sign_negative    = s2_result_ff.sign_negative;
   assign rsp_if.null_operator    = s2_result_ff.null_operator;
   assign rsp_if.out_of_range     = s2_result_ff.out_of_range;

   a_null_clears_result: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_result_ff.null_operator |->
         s2_result_ff.hole_address == '0 && s2_result_ff.particle_address == '0 &&
         !s2_result_ff.sign_negative && !s2_result_ff.out_of_range)
      else $error("null operator result carries data");

   a_range_clears_result: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_result_ff.out_of_range |->
         s2_result_ff.hole_address == '0 && s2_result_ff.particle_address == '0 &&
         !s2_result_ff.sign_negative && !s2_result_ff.null_operator)
      else $error("out of range result carries data");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff && $stable(s1_spec_ff))
      else $error("item in input register lost or overwritten");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ===== rtl/fexc_cfg.sv =====
// configuration registers and registered decode into per-orbital masks and shift counts
module fexc_cfg #(
   parameter int MAX_ORBITALS  = fexc_pkg::DEF_MAX_ORBITALS,
   parameter int MAX_OPERATORS = fexc_pkg::DEF_MAX_OPERATORS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_write_enable,
   input  logic [fexc_pkg::CSR_INDEX_W-1:0]               csr_index,
   input  logic [fexc_pkg::csr_width(MAX_OPERATORS)-1:0]  csr_write_data,
   output fexc_pkg::fexc_decode_type                      decode,
   output logic [MAX_ORBITALS-1:0]                        hole_mask,
   output logic [MAX_ORBITALS-1:0]                        particle_mask,
   output logic [MAX_ORBITALS-1:0]                        sign_mask,
   output logic [MAX_ORBITALS-1:0][fexc_pkg::shift_width(MAX_OPERATORS)-1:0] shift_count
);
   import fexc_pkg::*;

   localparam int LIST_W  = ENTRY_W * MAX_OPERATORS;
   localparam int SHIFT_W = shift_width(MAX_OPERATORS);

   logic [ORBITAL_COUNT_W-1:0] orbital_count_ff;
   logic [COUNT_W-1:0]         hole_count_ff;
   logic [COUNT_W-1:0]         particle_count_ff;
   logic [LIST_W-1:0]          hole_list_ff;
   logic [LIST_W-1:0]          particle_list_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orbital_count_ff  <= RESET_ORBITAL_COUNT;
         hole_count_ff     <= '0;
         particle_count_ff <= '0;
         hole_list_ff      <= '0;
         particle_list_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_ORBITAL_COUNT:  orbital_count_ff  <= csr_write_data[ORBITAL_COUNT_W-1:0];
            REG_HOLE_COUNT:     hole_count_ff     <= csr_write_data[COUNT_W-1:0];
            REG_PARTICLE_COUNT: particle_count_ff <= csr_write_data[COUNT_W-1:0];
            REG_HOLE_LIST:      hole_list_ff      <= csr_write_data[LIST_W-1:0];
            REG_PARTICLE_LIST:  particle_list_ff  <= csr_write_data[LIST_W-1:0];
            default: ;
         endcase
      end
   end

   logic [MAX_OPERATORS-1:0][ENTRY_W-1:0] h_entry;
   logic [MAX_OPERATORS-1:0][ENTRY_W-1:0] p_entry;
   logic [MAX_OPERATORS-1:0]              h_used;
   logic [MAX_OPERATORS-1:0]              p_used;
   logic [MAX_OPERATORS-1:0]              p_dup;
   logic [POS_W-1:0]                      n_eff;
   logic [POS_W-1:0]                      spec_bits;
   logic [SHIFT_W-1:0]                    used_count;

   fexc_decode_type                        decode_in, decode_ff;
   logic [MAX_ORBITALS-1:0]                hole_mask_in, hole_mask_ff;
   logic [MAX_ORBITALS-1:0]                particle_mask_in, particle_mask_ff;
   logic [MAX_ORBITALS-1:0]                sign_mask_in, sign_mask_ff;
   logic [MAX_ORBITALS-1:0][SHIFT_W-1:0]   shift_count_in, shift_count_ff;

   assign h_entry = hole_list_ff;
   assign p_entry = particle_list_ff;

   always_comb begin
      n_eff = ({1'b0, orbital_count_ff} > POS_W'(MAX_ORBITALS)) ?
              POS_W'(MAX_ORBITALS) : POS_W'(orbital_count_ff);

      for (int k = 0; k < MAX_OPERATORS; k++) begin
         h_used[k] = (k < int'(hole_count_ff));
         p_used[k] = (k < int'(particle_count_ff));
      end

      decode_in        = '0;
      hole_mask_in     = '0;
      particle_mask_in = '0;
      sign_mask_in     = '0;
      shift_count_in   = '0;
      used_count       = '0;

      // out of range entries, repeats and the order parity of each list
      for (int k = 0; k < MAX_OPERATORS; k++) begin
         if (h_used[k] && POS_W'(h_entry[k]) >= n_eff) decode_in.null_operator = 1'b1;
         if (p_used[k] && POS_W'(p_entry[k]) >= n_eff) decode_in.null_operator = 1'b1;
         for (int j = 0; j < k; j++) begin
            if (h_used[k] && h_entry[j] == h_entry[k]) decode_in.null_operator = 1'b1;
            if (p_used[k] && p_entry[j] == p_entry[k]) decode_in.null_operator = 1'b1;
            if (h_used[k] && h_entry[k] > h_entry[j])
               decode_in.inversion_parity = ~decode_in.inversion_parity;
            if (p_used[k] && p_entry[k] > p_entry[j])
               decode_in.inversion_parity = ~decode_in.inversion_parity;
         end
      end

      // a particle on a hole orbital takes the same slot
      for (int k = 0; k < MAX_OPERATORS; k++) begin
         p_dup[k] = 1'b0;
         for (int j = 0; j < MAX_OPERATORS; j++)
            if (h_used[j] && h_entry[j] == p_entry[k]) p_dup[k] = 1'b1;
         used_count = used_count + SHIFT_W'(h_used[k]) + SHIFT_W'(p_used[k] & ~p_dup[k]);
      end

      for (int q = 0; q < MAX_ORBITALS; q++) begin
         for (int k = 0; k < MAX_OPERATORS; k++) begin
            if (h_used[k] && POS_W'(h_entry[k]) == POS_W'(q)) hole_mask_in[q] = 1'b1;
            if (p_used[k] && POS_W'(p_entry[k]) == POS_W'(q)) particle_mask_in[q] = 1'b1;
            if (h_used[k] && POS_W'(h_entry[k]) < POS_W'(q)) begin
               sign_mask_in[q]   = ~sign_mask_in[q];
               shift_count_in[q] = shift_count_in[q] + SHIFT_W'(1);
            end
            if (p_used[k] && POS_W'(p_entry[k]) < POS_W'(q)) begin
               sign_mask_in[q] = ~sign_mask_in[q];
               if (!p_dup[k]) shift_count_in[q] = shift_count_in[q] + SHIFT_W'(1);
            end
         end
         if (POS_W'(q) >= n_eff) sign_mask_in[q] = 1'b0;
      end

      spec_bits = n_eff - POS_W'(used_count);
      for (int i = 0; i < DATA_W; i++)
         decode_in.range_mask[i] = (POS_W'(i) >= spec_bits);
   end

   always_ff @(posedge clock) begin
      decode_ff        <= decode_in;
      hole_mask_ff     <= hole_mask_in;
      particle_mask_ff <= particle_mask_in;
      sign_mask_ff     <= sign_mask_in;
      shift_count_ff   <= shift_count_in;
   end

   assign decode        = decode_ff;
   assign hole_mask     = hole_mask_ff;
   assign particle_mask = particle_mask_ff;
   assign sign_mask     = sign_mask_ff;
   assign shift_count   = shift_count_ff;

endmodule

// ===== rtl/fexc_expand.sv =====
// zero insertion at operator orbitals, range check and phase parity for one item
module fexc_expand #(
   parameter int MAX_ORBITALS  = fexc_pkg::DEF_MAX_ORBITALS,
   parameter int MAX_OPERATORS = fexc_pkg::DEF_MAX_OPERATORS
) (
   input  logic [fexc_pkg::DATA_W-1:0]  spectator_index,
   input  fexc_pkg::fexc_decode_type    decode,
   input  logic [MAX_ORBITALS-1:0]      hole_mask,
   input  logic [MAX_ORBITALS-1:0]      particle_mask,
   input  logic [MAX_ORBITALS-1:0]      sign_mask,
   input  logic [MAX_ORBITALS-1:0][fexc_pkg::shift_width(MAX_OPERATORS)-1:0] shift_count,
   output fexc_pkg::fexc_result_type    result
);
   import fexc_pkg::*;

   localparam int SHIFT_W   = shift_width(MAX_OPERATORS);
   localparam int MAX_SHIFT = 2 * MAX_OPERATORS;

   logic [MAX_ORBITALS-1:0] det_w;
   logic [MAX_ORBITALS-1:0] expanded;
   logic [MAX_ORBITALS-1:0] hole_det;
   logic [MAX_ORBITALS-1:0] particle_det;
   logic                    range_hit;
   logic                    parity;

   assign det_w = MAX_ORBITALS'(spectator_index);

   // each free orbital takes the spectator bit that sits shift_count places lower
   always_comb begin
      int src;
      expanded = '0;
      for (int q = 0; q < MAX_ORBITALS; q++) begin
         for (int s = 0; s <= MAX_SHIFT; s++) begin
            src = (q >= s) ? (q - s) : 0;
            if (q >= s && shift_count[q] == SHIFT_W'(s) && !(hole_mask[q] || particle_mask[q]))
               expanded[q] = det_w[src];
         end
      end
   end

   assign range_hit    = |(spectator_index & decode.range_mask);
   assign hole_det     = expanded | hole_mask;
   assign particle_det = expanded | particle_mask;
   assign parity       = (^(expanded & sign_mask)) ^ decode.inversion_parity;

   always_comb begin
      result = '0;
      priority if (decode.null_operator) begin
         result.null_operator = 1'b1;
      end else if (range_hit) begin
         result.out_of_range = 1'b1;
      end else begin
         result.hole_address     = DATA_W'(hole_det);
         result.particle_address = DATA_W'(particle_det);
         result.sign_negative    = parity;
      end
   end

endmodule

// ===== verif/fexc_result_checker.sv =====
// checker for the excitation block: predicts each result from the register copy and compares
module fexc_result_checker (
   input  logic                                                      clock,
   input  logic                                                      reset,
   input  logic                                                      csr_write_enable,
   input  logic [fexc_pkg::CSR_INDEX_W-1:0]                          csr_index,
   input  logic [fexc_pkg::csr_width(fexc_pkg::DEF_MAX_OPERATORS)-1:0] csr_write_data,
   input  logic                                                      req_valid,
   input  logic                                                      req_ready,
   input  logic [fexc_pkg::DATA_W-1:0]                               req_spectator_index,
   input  logic                                                      rsp_valid,
   input  logic                                                      rsp_ready,
   input  fexc_pkg::fexc_result_type                                 rsp_result,
   output int                                                        failures,
   output int                                                        results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fexc_pkg::*;

   localparam int LIST_W = ENTRY_W * DEF_MAX_OPERATORS;

   logic [ORBITAL_COUNT_W-1:0] orbitals;
   logic [COUNT_W-1:0]         hole_entries;
   logic [COUNT_W-1:0]         particle_entries;
   logic [LIST_W-1:0]          hole_orbitals;
   logic [LIST_W-1:0]          particle_orbitals;

   fexc_result_type expected_results[$];

   // occupancy mask of a list; clears ok on a repeat or an orbital past the count
   function automatic logic [63:0] orbital_mask(input logic [LIST_W-1:0] list, input int count,
                                                input int n, inout logic ok);
      logic [63:0] mask;
      logic [ENTRY_W-1:0] orb;
      mask = '0;
      for (int k = 0; k < count; k++) begin
         orb = list[ENTRY_W*k +: ENTRY_W];
         if (orb >= n || mask[orb]) ok = 1'b0;
         mask[orb] = 1'b1;
      end
      return mask;
   endfunction

   // parity of occupied orbitals above each listed one, each popped after use
   function automatic logic popped_parity(input logic [63:0] det, input logic [LIST_W-1:0] list,
                                          input int count, input int n);
      logic parity;
      logic [ENTRY_W-1:0] orb;
      parity = 1'b0;
      for (int k = 0; k < count; k++) begin
         orb = list[ENTRY_W*k +: ENTRY_W];
         for (int q = orb + 1; q < n; q++) parity ^= det[q];
         det[orb] = ~det[orb];
      end
      return parity;
   endfunction

   function automatic fexc_result_type expand_and_sign(input logic [DATA_W-1:0] spectator);
      fexc_result_type r;
      int n, nh, np, free_bits;
      logic ok;
      logic [63:0] hole_mask, particle_mask, occupied, det;
      r = '0;
      ok = 1'b1;
      n = (orbitals > DEF_MAX_ORBITALS) ? DEF_MAX_ORBITALS : int'(orbitals);
      nh = (hole_entries > DEF_MAX_OPERATORS) ? DEF_MAX_OPERATORS : int'(hole_entries);
      np = (particle_entries > DEF_MAX_OPERATORS) ? DEF_MAX_OPERATORS : int'(particle_entries);
      hole_mask = orbital_mask(hole_orbitals, nh, n, ok);
      particle_mask = orbital_mask(particle_orbitals, np, n, ok);
      if (!ok) begin
         r.null_operator = 1'b1;
         return r;
      end
      occupied = hole_mask | particle_mask;
      free_bits = n - $countones(occupied);
      det = 64'(spectator);
      if ((det >> free_bits) != 0) begin
         r.out_of_range = 1'b1;
         return r;
      end
      // open a zero slot at every hole or particle orbital, lowest first
      for (int p = 0; p < n; p++)
         if (occupied[p]) det = ((det >> p) << (p + 1)) | (det & ((64'd1 << p) - 64'd1));
      r.hole_address = DATA_W'(det | hole_mask);
      r.particle_address = DATA_W'(det | particle_mask);
      r.sign_negative = popped_parity(det | hole_mask, hole_orbitals, nh, n) ^
                        popped_parity(det | particle_mask, particle_orbitals, np, n);
      return r;
   endfunction

   always @(posedge clock) begin : track
      fexc_result_type want;
      logic bad;
      if (reset) begin
         orbitals = RESET_ORBITAL_COUNT;
         hole_entries = '0;
         particle_entries = '0;
         hole_orbitals = '0;
         particle_orbitals = '0;
         expected_results.delete();
         failures <= 0;
         results_pending <= 0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               REG_ORBITAL_COUNT:  orbitals = csr_write_data[ORBITAL_COUNT_W-1:0];
               REG_HOLE_COUNT:     hole_entries = csr_write_data[COUNT_W-1:0];
               REG_PARTICLE_COUNT: particle_entries = csr_write_data[COUNT_W-1:0];
               REG_HOLE_LIST:      hole_orbitals = csr_write_data[LIST_W-1:0];
               REG_PARTICLE_LIST:  particle_orbitals = csr_write_data[LIST_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result item with none expected: hole %h particle %h", $realtime,
                           rsp_result.hole_address, rsp_result.particle_address);
               failures <= failures + 1;
            end else begin
               want = expected_results.pop_front();
               bad = (rsp_result.hole_address !== want.hole_address) ||
                     (rsp_result.particle_address !== want.particle_address) ||
                     (rsp_result.sign_negative !== want.sign_negative) ||
                     (rsp_result.null_operator !== want.null_operator) ||
                     (rsp_result.out_of_range !== want.out_of_range);
               if (bad) begin
                  if (failures < 10)
                     $display({"%0t: mismatch exp hole %h part %h sgn %b null %b oor %b,",
                               " got %h %h %b %b %b"},
                              $realtime, want.hole_address, want.particle_address,
                              want.sign_negative, want.null_operator, want.out_of_range,
                              rsp_result.hole_address, rsp_result.particle_address,
                              rsp_result.sign_negative, rsp_result.null_operator,
                              rsp_result.out_of_range);
                  failures <= failures + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_results.push_back(expand_and_sign(req_spectator_index));
         results_pending <= expected_results.size();
      end
   end
endmodule

// ===== verif/fermion_excitation_index_and_sign_tb.sv =====
// top of the excitation block testbench: clock, reset, register setup, item traffic and verdict
module fermion_excitation_index_and_sign_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fexc_pkg::*;

   localparam int CSR_W  = csr_width(DEF_MAX_OPERATORS);
   localparam int LIST_W = ENTRY_W * DEF_MAX_OPERATORS;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_write_data;
   int                     failures;
   int                     results_pending;
   int                     send_idle_pct;
   int                     recv_stall_pct;
   int                     free_bits;

   fexc_req_if req_ch();
   fexc_rsp_if rsp_ch();

   fermion_excitation_index_and_sign dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   fexc_result_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_spectator_index (req_ch.spectator_index),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_result          ({rsp_ch.hole_address, rsp_ch.particle_address, rsp_ch.sign_negative,
                             rsp_ch.null_operator, rsp_ch.out_of_range}),
      .failures            (failures),
      .results_pending     (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [LIST_W-1:0] pack4(input int a, input int b, input int c, input int d);
      return {5'(d), 5'(c), 5'(b), 5'(a)};
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic set_config(input logic [5:0] n, input logic [2:0] hc, input logic [2:0] pc,
                             input logic [LIST_W-1:0] hl, input logic [LIST_W-1:0] pl);
      int span;
      logic [31:0] used;
      logic [4:0] orb;
      write_reg(REG_ORBITAL_COUNT, CSR_W'(n));
      write_reg(REG_HOLE_COUNT, CSR_W'(hc));
      write_reg(REG_PARTICLE_COUNT, CSR_W'(pc));
      write_reg(REG_HOLE_LIST, hl);
      write_reg(REG_PARTICLE_LIST, pl);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // width of the spectator space, used to aim items at its edges
      span = (n > DEF_MAX_ORBITALS) ? DEF_MAX_ORBITALS : int'(n);
      used = '0;
      for (int k = 0; k < DEF_MAX_OPERATORS; k++) begin
         orb = hl[ENTRY_W*k +: ENTRY_W];
         if (k < hc && orb < span) used[orb] = 1'b1;
         orb = pl[ENTRY_W*k +: ENTRY_W];
         if (k < pc && orb < span) used[orb] = 1'b1;
      end
      free_bits = span - $countones(used);
      // wait for the registered decode to take the last write
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [LIST_W-1:0] distinct_orbitals(input logic [LIST_W-1:0] list,
                                                           input int count, input int span);
      logic [31:0] taken;
      int orb;
      taken = '0;
      for (int k = 0; k < count; k++) begin
         do orb = $urandom_range(0, span - 1); while (taken[orb]);
         taken[orb] = 1'b1;
         list[ENTRY_W*k +: ENTRY_W] = 5'(orb);
      end
      return list;
   endfunction

   task automatic random_config();
      logic [5:0] n;
      logic [2:0] hc, pc;
      logic [LIST_W-1:0] hl, pl;
      int span;
      hl = LIST_W'($urandom);
      pl = LIST_W'($urandom);
      if ($urandom_range(99) < 15) begin
         set_config(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), hl, pl);
      end else begin
         n = ($urandom_range(99) < 10) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(1, 32));
         span = (n > DEF_MAX_ORBITALS) ? DEF_MAX_ORBITALS : int'(n);
         hc = 3'($urandom_range(0, (span < DEF_MAX_OPERATORS) ? span : DEF_MAX_OPERATORS));
         pc = 3'($urandom_range(0, (span < DEF_MAX_OPERATORS) ? span : DEF_MAX_OPERATORS));
         hl = distinct_orbitals(hl, hc, span);
         pl = distinct_orbitals(pl, pc, span);
         // full lists sometimes carry a count that saturates
         if (hc == DEF_MAX_OPERATORS && $urandom_range(3) == 0) hc = 3'($urandom_range(5, 7));
         if (pc == DEF_MAX_OPERATORS && $urandom_range(3) == 0) pc = 3'($urandom_range(5, 7));
         set_config(n, hc, pc, hl, pl);
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_spectator();
      logic [63:0] limit;
      int roll;
      limit = 64'd1 << free_bits;
      roll = $urandom_range(99);
      if (roll < 70) return DATA_W'({$urandom, $urandom} & (limit - 64'd1));
      if (roll < 78) return DATA_W'(limit - 64'd1);
      if (roll < 84) return DATA_W'(limit);
      if (roll < 88) return '0;
      return $urandom;
   endfunction

   task automatic send_item(input logic [DATA_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.spectator_index <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // wait for every expected result, then out the pipeline latency
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pressure(input int mode);
      unique case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
         default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= REG_ORBITAL_COUNT;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.spectator_index <= '0;
      set_pressure(0);
      free_bits = DEF_MAX_ORBITALS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings after reset: all orbitals are spectators
      send_item('0);
      send_item('1);
      send_item(32'h8000_0000);
      settle();
      set_config(4, 1, 1, pack4(1, 0, 0, 0), pack4(2, 0, 0, 0));
      for (int v = 0; v <= 4; v++) send_item(DATA_W'(v));
      settle();
      set_config(32, 4, 4, pack4(5, 17, 0, 31), pack4(3, 2, 1, 30));
      send_item('0);
      send_item(32'h00FF_FFFF);
      send_item(32'h0100_0000);
      send_item(32'h00A5_5A5A);
      settle();
      // repeated hole
      set_config(32, 2, 1, pack4(7, 7, 0, 0), pack4(3, 0, 0, 0));
      send_item(32'h0000_0001);
      settle();
      // repeated particle
      set_config(32, 1, 3, pack4(3, 0, 0, 0), pack4(9, 4, 9, 0));
      send_item(32'h0000_0001);
      settle();
      // hole and particle sharing orbitals is legal
      set_config(8, 2, 2, pack4(6, 2, 0, 0), pack4(2, 6, 0, 0));
      send_item(32'h0000_003F);
      send_item(32'h0000_0040);
      settle();
      // orbital past the orbital count
      set_config(6, 1, 1, pack4(6, 0, 0, 0), pack4(0, 0, 0, 0));
      send_item('0);
      settle();
      set_config(0, 0, 0, '0, '0);
      send_item('0);
      send_item(32'h0000_0001);
      settle();
      set_config(0, 1, 0, '0, '0);
      send_item('0);
      settle();
      // counts above the list size saturate
      set_config(16, 7, 5, pack4(0, 15, 8, 3), pack4(1, 2, 4, 12));
      send_item(32'h0000_00C3);
      settle();
      set_config(63, 0, 0, '0, '0);
      send_item('1);
      settle();
      set_config(1, 0, 0, '0, '0);
      send_item(32'h0000_0001);
      send_item(32'h0000_0002);
      settle();
      set_config(32, 1, 2, '1, '1);
      send_item('0);

      for (int phase = 0; phase < 16; phase++) begin
         settle();
         random_config();
         set_pressure(phase % 4);
         repeat (40) send_item(pick_spectator());
      end
      settle();

      if (failures == 0 && results_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/fexc_pkg.sv
rtl/fexc_channels.sv
rtl/fexc_cfg.sv
rtl/fexc_expand.sv
rtl/fermion_excitation_index_and_sign.sv
verif/fexc_result_checker.sv
verif/fermion_excitation_index_and_sign_tb.sv
